// File: rtl/tga_pkg.sv
// Shared types and codes for the TGA run-length image decoder.
`default_nettype none

package tga_pkg;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_CMAP      = 3'd0;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
	localparam logic [2:0] ERR_EMPTY     = 3'd2;
	localparam logic [2:0] ERR_BAD_DEPTH = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;
	localparam logic [2:0] ERR_RUN_OVER  = 3'd5;

	// Width of the packed result payload on the output bus
	localparam int unsigned RES_TDATA_W = 88;

	// One decoder result
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  image_descriptor;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic        last_pixel;
		logic [2:0]  error_code;
	} tga_result_t;

endpackage

`default_nettype wire

// File: rtl/tga_decode.sv
// Byte-level header parser and pixel decoder state with its next-state logic.
`default_nettype none

module tga_decode (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,
	input  wire [7:0]            data_byte,
	input  wire                  end_of_file,
	output logic                 has_result,
	output tga_pkg::tga_result_t result
);

	// Parser phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IDSKIP = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_DRAIN  = 3'd4;

	// Header byte offsets
	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_DEPTH     = 5'd16;
	localparam logic [4:0] HDR_DESC      = 5'd17;

	// Depth codes
	localparam logic [1:0] DEPTH_8     = 2'd0;
	localparam logic [1:0] DEPTH_24    = 2'd1;
	localparam logic [1:0] DEPTH_32    = 2'd2;
	localparam logic [1:0] DEPTH_OTHER = 2'd3;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  header_index_q, header_index_d;
	logic [7:0]  id_skip_q, id_skip_d;
	logic        is_rle_q, is_rle_d;
	logic [1:0]  depth_q, depth_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  desc_q, desc_d;
	logic [31:0] pixels_left_q, pixels_left_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic        run_packet_q, run_packet_d;
	logic [1:0]  pbi_q, pbi_d;
	logic [23:0] pixel_bytes_q, pixel_bytes_d;
	logic        fault_q, fault_d;
	logic [2:0]  fault_code_q, fault_code_d;

	logic        do_err;
	logic [2:0]  err_code;
	logic        do_restart;
	logic        restart_eof;
	logic        rle_new;
	logic [7:0]  count;
	logic [2:0]  nbytes;
	logic [23:0] merged;
	logic [23:0] bytes;
	logic [7:0]  rep_raw;
	logic [7:0]  rep;
	logic [31:0] pixels_new;
	logic [7:0]  packet_new;
	logic        last;
	logic [31:0] area;

	assign area   = 32'(width_q) * 32'(height_q);
	assign merged = pixel_bytes_q | (24'(data_byte) << {pbi_q, 3'b000});

	// Next-state and result for the byte in the input register
	always_comb begin
		phase_d        = phase_q;
		header_index_d = header_index_q;
		id_skip_d      = id_skip_q;
		is_rle_d       = is_rle_q;
		depth_d        = depth_q;
		width_d        = width_q;
		height_d       = height_q;
		desc_d         = desc_q;
		pixels_left_d  = pixels_left_q;
		packet_left_d  = packet_left_q;
		run_packet_d   = run_packet_q;
		pbi_d          = pbi_q;
		pixel_bytes_d  = pixel_bytes_q;
		fault_d        = fault_q;
		fault_code_d   = fault_code_q;
		has_result     = 1'b0;
		result         = '0;
		do_err         = 1'b0;
		err_code       = tga_pkg::ERR_CMAP;
		do_restart     = 1'b0;
		restart_eof    = 1'b0;
		rle_new        = 1'b0;
		count          = {1'b0, data_byte[6:0]} + 8'd1;
		nbytes         = (depth_q == DEPTH_24) ? 3'd3 : (depth_q == DEPTH_32) ? 3'd4 : 3'd1;
		bytes          = (pbi_q != 2'd3) ? merged : pixel_bytes_q;
		rep_raw        = (is_rle_q && run_packet_q) ? packet_left_q : 8'd1;
		rep            = (pixels_left_q < 32'(rep_raw)) ? pixels_left_q[7:0] : rep_raw;
		pixels_new     = pixels_left_q - 32'(rep);
		packet_new     = (packet_left_q >= rep) ? packet_left_q - rep : 8'd0;
		last           = (pixels_new == 32'd0);

		unique case (phase_q)
			PH_HEADER: begin
				// header field capture
				unique case (header_index_q)
					HDR_ID_LEN: id_skip_d = data_byte;
					HDR_CMAP_TYPE: begin
						if (data_byte != 8'd0 && !fault_q) begin
							fault_d      = 1'b1;
							fault_code_d = tga_pkg::ERR_CMAP;
						end
					end
					HDR_IMG_TYPE: begin
						rle_new  = (data_byte == 8'd10) || (data_byte == 8'd11);
						is_rle_d = rle_new;
						if (data_byte != 8'd2 && data_byte != 8'd3 && !rle_new && !fault_q) begin
							fault_d      = 1'b1;
							fault_code_d = tga_pkg::ERR_BAD_TYPE;
						end
					end
					HDR_WIDTH_LO:  width_d  = {width_q[15:8], data_byte};
					HDR_WIDTH_HI:  width_d  = {data_byte, width_q[7:0]};
					HDR_HEIGHT_LO: height_d = {height_q[15:8], data_byte};
					HDR_HEIGHT_HI: height_d = {data_byte, height_q[7:0]};
					HDR_DEPTH: begin
						depth_d = (data_byte == 8'd8)  ? DEPTH_8  :
						          (data_byte == 8'd24) ? DEPTH_24 :
						          (data_byte == 8'd32) ? DEPTH_32 : DEPTH_OTHER;
					end
					HDR_DESC: desc_d = data_byte;
					default: ;
				endcase
				if (header_index_q < HDR_DESC) begin
					header_index_d = header_index_q + 5'd1;
					if (end_of_file) begin
						do_err      = 1'b1;
						err_code    = tga_pkg::ERR_TRUNCATED;
						restart_eof = 1'b1;
					end
				end else if (fault_q) begin
					do_err      = 1'b1;
					err_code    = fault_code_q;
					restart_eof = end_of_file;
				end else if (width_q == 16'd0 || height_q == 16'd0) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_EMPTY;
					restart_eof = end_of_file;
				end else if (!is_rle_q && depth_q == DEPTH_OTHER) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_BAD_DEPTH;
					restart_eof = end_of_file;
				end else if (end_of_file) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_TRUNCATED;
					restart_eof = 1'b1;
				end else begin
					// header accepted
					header_index_d = 5'd0;
					pixels_left_d  = area;
					packet_left_d  = 8'd0;
					run_packet_d   = 1'b0;
					pbi_d          = 2'd0;
					pixel_bytes_d  = 24'd0;
					if (id_skip_q != 8'd0) phase_d = PH_IDSKIP;
					else phase_d = is_rle_q ? PH_PACKET : PH_PIXEL;
					has_result              = 1'b1;
					result.kind             = tga_pkg::KIND_HEADER;
					result.image_width      = width_q;
					result.image_height     = height_q;
					result.image_descriptor = data_byte;
				end
			end
			PH_IDSKIP: begin
				id_skip_d = id_skip_q - 8'd1;
				if (end_of_file) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_TRUNCATED;
					restart_eof = 1'b1;
				end else if (id_skip_d == 8'd0) begin
					phase_d = is_rle_q ? PH_PACKET : PH_PIXEL;
				end
			end
			PH_PACKET: begin
				if (32'(count) > pixels_left_q) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_RUN_OVER;
					restart_eof = end_of_file;
				end else if (depth_q == DEPTH_OTHER) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_BAD_DEPTH;
					restart_eof = end_of_file;
				end else if (end_of_file) begin
					do_err      = 1'b1;
					err_code    = tga_pkg::ERR_TRUNCATED;
					restart_eof = 1'b1;
				end else begin
					packet_left_d = count;
					run_packet_d  = data_byte[7];
					pbi_d         = 2'd0;
					pixel_bytes_d = 24'd0;
					phase_d       = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				if (3'(pbi_q) + 3'd1 < nbytes) begin
					// gather a byte of a multi-byte pixel
					pixel_bytes_d = merged;
					pbi_d         = pbi_q + 2'd1;
					if (end_of_file) begin
						do_err      = 1'b1;
						err_code    = tga_pkg::ERR_TRUNCATED;
						restart_eof = 1'b1;
					end
				end else begin
					pixel_bytes_d = 24'd0;
					pbi_d         = 2'd0;
					pixels_left_d = pixels_new;
					if (is_rle_q) packet_left_d = packet_new;
					if (!last && end_of_file) begin
						do_err      = 1'b1;
						err_code    = tga_pkg::ERR_TRUNCATED;
						restart_eof = 1'b1;
					end else begin
						has_result  = 1'b1;
						result.kind = tga_pkg::KIND_PIXEL;
						if (nbytes == 3'd1) begin
							result.blue  = bytes[7:0];
							result.green = bytes[7:0];
							result.red   = bytes[7:0];
						end else begin
							result.blue  = bytes[7:0];
							result.green = bytes[15:8];
							result.red   = bytes[23:16];
						end
						result.alpha      = (nbytes == 3'd4) ? data_byte : 8'hFF;
						result.repeat_res = rep;
						result.last_pixel = last;
						if (last) begin
							do_restart  = 1'b1;
							restart_eof = end_of_file;
						end else begin
							phase_d = (is_rle_q && packet_new == 8'd0) ? PH_PACKET : PH_PIXEL;
						end
					end
				end
			end
			default: begin
				// drain until end of file
				if (end_of_file) begin
					do_restart  = 1'b1;
					restart_eof = 1'b1;
				end
			end
		endcase

		// error result
		if (do_err) begin
			has_result        = 1'b1;
			result            = '0;
			result.kind       = tga_pkg::KIND_ERROR;
			result.error_code = err_code;
			do_restart        = 1'b1;
		end

		// back to the header, or drain the rest of the file
		if (do_restart) begin
			phase_d        = restart_eof ? PH_HEADER : PH_DRAIN;
			header_index_d = 5'd0;
			fault_d        = 1'b0;
			fault_code_d   = tga_pkg::ERR_CMAP;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_index_q <= 5'd0;
			id_skip_q      <= 8'd0;
			is_rle_q       <= 1'b0;
			depth_q        <= DEPTH_8;
			width_q        <= 16'd0;
			height_q       <= 16'd0;
			desc_q         <= 8'd0;
			pixels_left_q  <= 32'd0;
			packet_left_q  <= 8'd0;
			run_packet_q   <= 1'b0;
			pbi_q          <= 2'd0;
			pixel_bytes_q  <= 24'd0;
			fault_q        <= 1'b0;
			fault_code_q   <= tga_pkg::ERR_CMAP;
		end else if (advance) begin
			phase_q        <= phase_d;
			header_index_q <= header_index_d;
			id_skip_q      <= id_skip_d;
			is_rle_q       <= is_rle_d;
			depth_q        <= depth_d;
			width_q        <= width_d;
			height_q       <= height_d;
			desc_q         <= desc_d;
			pixels_left_q  <= pixels_left_d;
			packet_left_q  <= packet_left_d;
			run_packet_q   <= run_packet_d;
			pbi_q          <= pbi_d;
			pixel_bytes_q  <= pixel_bytes_d;
			fault_q        <= fault_d;
			fault_code_q   <= fault_code_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tga_out_reg.sv
// Result register driving the master-side stream.
`default_nettype none

module tga_out_reg (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                load,
	input  wire tga_pkg::tga_result_t          result,
	output logic                               ready,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [tga_pkg::RES_TDATA_W-1:0]    m_axis_tdata,
	output logic [1:0]                         m_axis_tuser,
	output logic                               m_axis_tlast
);

	logic                 valid_q;
	tga_pkg::tga_result_t res_q;

	// free when empty or the held transaction leaves this cycle
	assign ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last_pixel;
	assign m_axis_tdata  = {5'd0, res_q.error_code, res_q.repeat_res, res_q.alpha,
	                        res_q.red, res_q.green, res_q.blue, res_q.image_descriptor,
	                        res_q.image_height, res_q.image_width};

endmodule

`default_nettype wire

// File: rtl/tga_rle_image_decoder.sv
// Top level of the streaming TGA true-colour / grey decoder, raw and run-length.
//
// Slave stream: one file byte per transaction in s_axis_tdata, s_axis_tlast
// on the last byte of the file. Master stream: one result per transaction,
// kind in m_axis_tuser (header, pixel run, error), last_pixel in m_axis_tlast.
// A pixel result from a run packet carries a repeat count rather than one
// transaction per pixel.
// Each accepted byte is held in an input register, decoded by the state
// logic and, if it yields a result, written into the result register, from
// which the result is presented. One byte is taken per cycle while the
// result register is free; the rate is set by the combinational decode step
// between the two registers, whose widest path is the 16x16 size product and
// the 32-bit pixel count update.
// When the receiver stalls, the result register holds its transaction, the
// input register fills and s_axis_tready drops until the result is taken.
// Reset empties both registers and returns the parser to the start of a
// header. After an error or a complete image, bytes up to end of file are
// consumed with no result.
`default_nettype none

module tga_rle_image_decoder (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire [7:0]                       s_axis_tdata,  // [7:0] data_byte
	input  wire                             s_axis_tlast,  // end_of_file
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// [15:0] image_width, [31:16] image_height, [39:32] image_descriptor,
	// [47:40] blue, [55:48] green, [63:56] red, [71:64] alpha,
	// [79:72] repeat_res, [82:80] error_code, [87:83] zero
	output logic [tga_pkg::RES_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,  // [1:0] kind
	output logic                            m_axis_tlast   // last_pixel
);

	logic                 in_valid_s1;
	logic [7:0]           in_byte_s1;
	logic                 in_eof_s1;
	logic                 out_ready;
	logic                 advance;
	logic                 has_result;
	tga_pkg::tga_result_t result;

	// decode the held byte whenever the result register can take it
	assign advance       = in_valid_s1 && out_ready;
	assign s_axis_tready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_eof_s1  <= s_axis_tlast;
		end
	end

	tga_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (in_byte_s1),
		.end_of_file (in_eof_s1),
		.has_result  (has_result),
		.result      (result)
	);

	tga_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && has_result),
		.result        (result),
		.ready         (out_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: bench/tga_result_checker.sv
// Scoreboard for the TGA decoder: predicts each result from the byte stream and checks the output.
`timescale 1ns / 1ps

module tga_result_checker
	import tga_pkg::*;
(
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	input  wire                             s_axis_tready,
	input  wire [7:0]                       s_axis_tdata,  // [7:0] data_byte
	input  wire                             s_axis_tlast,  // end_of_file
	input  wire                             m_axis_tvalid,
	input  wire                             m_axis_tready,
	input  wire [tga_pkg::RES_TDATA_W-1:0] m_axis_tdata,  // see the decoder port list
	input  wire [1:0]                       m_axis_tuser,  // [1:0] kind
	input  wire                             m_axis_tlast,  // last_pixel
	output int unsigned                     results_pending,
	output int unsigned                     mismatches
);

	// Header byte offsets
	localparam logic [4:0] HDR_ID_LEN     = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
	localparam logic [4:0] HDR_DEPTH      = 5'd16;
	localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

	// Image types and pixel depths that the decoder accepts
	localparam logic [7:0] IMG_RAW_COLOUR = 8'd2;
	localparam logic [7:0] IMG_RAW_GREY   = 8'd3;
	localparam logic [7:0] IMG_RLE_COLOUR = 8'd10;
	localparam logic [7:0] IMG_RLE_GREY   = 8'd11;
	localparam logic [7:0] BPP_GREY       = 8'd8;
	localparam logic [7:0] BPP_RGB        = 8'd24;
	localparam logic [7:0] BPP_RGBA       = 8'd32;

	typedef enum logic [2:0] {
		ST_HEADER, ST_ID_SKIP, ST_PACKET, ST_PIXEL, ST_DRAIN
	} parse_state_e;

	typedef enum logic [1:0] {
		DEPTH_8, DEPTH_24, DEPTH_32, DEPTH_OTHER
	} depth_e;

	// Predictor state
	parse_state_e phase_q;
	logic [4:0]   hdr_idx;
	logic [7:0]   id_left;
	logic         rle;
	depth_e       depth;
	logic [15:0]  width_q;
	logic [15:0]  height_q;
	logic [7:0]   desc_q;
	logic [31:0]  pix_left;
	logic [7:0]   pkt_left;
	logic         run_pkt;
	logic [1:0]   pix_byte_idx;
	logic [23:0]  pix_acc;
	logic         hdr_bad;
	logic [2:0]   hdr_bad_code;

	tga_result_t  pred;
	tga_result_t  results_due[$];
	int unsigned  fails;

	// Back to the start of a header on end of file, otherwise skip to end of file
	function automatic void restart(input logic eof);
		phase_q = eof ? ST_HEADER : ST_DRAIN;
		hdr_idx = '0;
		hdr_bad = 1'b0;
		hdr_bad_code = ERR_CMAP;
	endfunction

	function automatic bit flag_error(input logic [2:0] code, input logic eof);
		pred = '0;
		pred.kind = KIND_ERROR;
		pred.error_code = code;
		restart(eof);
		return 1'b1;
	endfunction

	// Advances the parser by one file byte; returns 1 when a result is due in pred
	function automatic bit decode_byte(input logic [7:0] b, input logic eof);
		logic [31:0]  count;
		logic [31:0]  rep;
		logic [23:0]  px;
		int unsigned  nbytes;
		logic         done;
		pred = '0;
		case (phase_q)
			ST_HEADER: begin
				case (hdr_idx)
					HDR_ID_LEN: id_left = b;
					HDR_CMAP_TYPE: begin
						if (b != 8'd0 && !hdr_bad) begin
							hdr_bad = 1'b1;
							hdr_bad_code = ERR_CMAP;
						end
					end
					HDR_IMG_TYPE: begin
						rle = (b == IMG_RLE_COLOUR || b == IMG_RLE_GREY);
						if (b != IMG_RAW_COLOUR && b != IMG_RAW_GREY && !rle && !hdr_bad) begin
							hdr_bad = 1'b1;
							hdr_bad_code = ERR_BAD_TYPE;
						end
					end
					HDR_WIDTH_LO: width_q[7:0] = b;
					HDR_WIDTH_HI: width_q[15:8] = b;
					HDR_HEIGHT_LO: height_q[7:0] = b;
					HDR_HEIGHT_HI: height_q[15:8] = b;
					HDR_DEPTH: depth = (b == BPP_GREY) ? DEPTH_8 : (b == BPP_RGB) ? DEPTH_24 :
						(b == BPP_RGBA) ? DEPTH_32 : DEPTH_OTHER;
					HDR_DESCRIPTOR: desc_q = b;
					default: ;
				endcase
				if (hdr_idx < HDR_DESCRIPTOR) begin
					hdr_idx = hdr_idx + 5'd1;
					if (eof)
						return flag_error(ERR_TRUNCATED, 1'b1);
					return 1'b0;
				end
				// checks in priority order on the descriptor byte
				if (hdr_bad)
					return flag_error(hdr_bad_code, eof);
				if (width_q == 16'd0 || height_q == 16'd0)
					return flag_error(ERR_EMPTY, eof);
				if (!rle && depth == DEPTH_OTHER)
					return flag_error(ERR_BAD_DEPTH, eof);
				if (eof)
					return flag_error(ERR_TRUNCATED, 1'b1);
				hdr_idx = '0;
				pix_left = 32'(width_q) * 32'(height_q);
				pkt_left = '0;
				run_pkt = 1'b0;
				pix_byte_idx = '0;
				pix_acc = '0;
				if (id_left != 8'd0)
					phase_q = ST_ID_SKIP;
				else
					phase_q = rle ? ST_PACKET : ST_PIXEL;
				pred.kind = KIND_HEADER;
				pred.image_width = width_q;
				pred.image_height = height_q;
				pred.image_descriptor = desc_q;
				return 1'b1;
			end
			ST_ID_SKIP: begin
				id_left = id_left - 8'd1;
				if (eof)
					return flag_error(ERR_TRUNCATED, 1'b1);
				if (id_left == 8'd0)
					phase_q = rle ? ST_PACKET : ST_PIXEL;
				return 1'b0;
			end
			ST_PACKET: begin
				// overflow is checked before the deferred depth check
				count = 32'(b[6:0]) + 32'd1;
				if (count > pix_left)
					return flag_error(ERR_RUN_OVER, eof);
				if (depth == DEPTH_OTHER)
					return flag_error(ERR_BAD_DEPTH, eof);
				if (eof)
					return flag_error(ERR_TRUNCATED, 1'b1);
				pkt_left = count[7:0];
				run_pkt = b[7];
				pix_byte_idx = '0;
				pix_acc = '0;
				phase_q = ST_PIXEL;
				return 1'b0;
			end
			ST_PIXEL: begin
				nbytes = (depth == DEPTH_24) ? 3 : (depth == DEPTH_32) ? 4 : 1;
				if (pix_byte_idx + 1 < nbytes) begin
					pix_acc[8*pix_byte_idx +: 8] = b;
					pix_byte_idx = pix_byte_idx + 2'd1;
					if (eof)
						return flag_error(ERR_TRUNCATED, 1'b1);
					return 1'b0;
				end
				// final byte of the pixel: alpha for 32-bit, otherwise a colour byte
				px = pix_acc;
				if (pix_byte_idx < 2'd3)
					px[8*pix_byte_idx +: 8] = b;
				pix_acc = '0;
				pix_byte_idx = '0;
				rep = (rle && run_pkt) ? 32'(pkt_left) : 32'd1;
				if (rep > pix_left)
					rep = pix_left;
				pix_left = pix_left - rep;
				if (rle)
					pkt_left = (32'(pkt_left) >= rep) ? pkt_left - rep[7:0] : 8'd0;
				done = (pix_left == 32'd0);
				if (!done && eof)
					return flag_error(ERR_TRUNCATED, 1'b1);
				pred.kind = KIND_PIXEL;
				if (nbytes == 1) begin
					pred.blue = px[7:0];
					pred.green = px[7:0];
					pred.red = px[7:0];
					pred.alpha = 8'hFF;
				end else begin
					pred.blue = px[7:0];
					pred.green = px[15:8];
					pred.red = px[23:16];
					pred.alpha = (nbytes == 4) ? b : 8'hFF;
				end
				pred.repeat_res = rep[7:0];
				pred.last_pixel = done;
				if (done)
					restart(eof);
				else
					phase_q = (rle && pkt_left == 8'd0) ? ST_PACKET : ST_PIXEL;
				return 1'b1;
			end
			default: begin
				// draining up to end of file
				if (eof)
					restart(1'b1);
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	// Compare output transactions, then predict from input transactions
	always @(posedge clk or negedge arst_n) begin
		tga_result_t want;
		if (!arst_n) begin
			phase_q = ST_HEADER;
			hdr_idx = '0;
			id_left = '0;
			rle = 1'b0;
			depth = DEPTH_8;
			width_q = '0;
			height_q = '0;
			desc_q = '0;
			pix_left = '0;
			pkt_left = '0;
			run_pkt = 1'b0;
			pix_byte_idx = '0;
			pix_acc = '0;
			hdr_bad = 1'b0;
			hdr_bad_code = ERR_CMAP;
			results_due.delete();
			fails = 0;
			results_pending <= 0;
			mismatches <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("result with nothing expected: kind %0d, tdata %h",
						m_axis_tuser, m_axis_tdata);
					fails++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
					check_field("image_width", 32'(want.image_width), 32'(m_axis_tdata[15:0]));
					check_field("image_height", 32'(want.image_height),
						32'(m_axis_tdata[31:16]));
					check_field("image_descriptor", 32'(want.image_descriptor),
						32'(m_axis_tdata[39:32]));
					check_field("blue", 32'(want.blue), 32'(m_axis_tdata[47:40]));
					check_field("green", 32'(want.green), 32'(m_axis_tdata[55:48]));
					check_field("red", 32'(want.red), 32'(m_axis_tdata[63:56]));
					check_field("alpha", 32'(want.alpha), 32'(m_axis_tdata[71:64]));
					check_field("repeat_res", 32'(want.repeat_res), 32'(m_axis_tdata[79:72]));
					check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[82:80]));
					check_field("tdata_pad", 32'd0, 32'(m_axis_tdata[87:83]));
					check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_byte(s_axis_tdata, s_axis_tlast))
					results_due.insert(results_due.size(), pred);
			end
			results_pending <= results_due.size();
			mismatches <= fails;
		end
	end

endmodule

// File: bench/tb_top.sv
// Top of the TGA decoder testbench: file stimulus, random flow control and the verdict.
`timescale 1ns / 1ps

module tb_top;
	import tga_pkg::*;

	localparam int unsigned BYTE_TARGET = 1100;
	localparam int unsigned CALM_AFTER  = 950;   // no idling past this many bytes
	localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transaction at all

	localparam logic [7:0] IMG_RAW_COLOUR = 8'd2;
	localparam logic [7:0] IMG_RAW_GREY   = 8'd3;
	localparam logic [7:0] IMG_RLE_COLOUR = 8'd10;
	localparam logic [7:0] IMG_RLE_GREY   = 8'd11;
	localparam logic [7:0] BPP_GREY       = 8'd8;
	localparam logic [7:0] BPP_RGB        = 8'd24;
	localparam logic [7:0] BPP_RGBA       = 8'd32;

	// Kinds of file the generator can build
	typedef enum int {
		FILE_CLEAN, FILE_TRAILING, FILE_CUT, FILE_EOF_AT_HEADER, FILE_RUN_OVER, FILE_CMAP,
		FILE_BAD_TYPE, FILE_EMPTY, FILE_BAD_DEPTH, FILE_HUGE, FILE_NOISE
	} file_shape_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [RES_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	int unsigned results_pending;
	int unsigned mismatches;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          send_gaps = 1'b1;
	bit          sink_stalls = 1'b1;
	logic [7:0]  file_q[$];

	always #5 clk = ~clk;

	tga_rle_image_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	tga_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.results_pending (results_pending),
		.mismatches      (mismatches)
	);

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Adds one byte at the end of the file being built
	function automatic void append_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endfunction

	// Watchdog: ends the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result sink with random stall bursts
	initial begin
		forever begin
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// One byte transaction, optionally preceded by an idle burst
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// Hold the sender off until every predicted result has been taken
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	// Builds one file into file_q; its last byte carries end of file when sent
	task automatic build_file(input file_shape_e shape);
		logic [7:0]  img_type;
		logic [7:0]  bpp;
		logic [7:0]  id_len;
		logic [15:0] w;
		logic [15:0] h;
		int unsigned nbytes;
		int unsigned owed;
		int unsigned count;
		int unsigned cut;
		bit          rle;
		bit          run;
		file_q.delete();
		if (shape == FILE_NOISE) begin
			repeat ($urandom_range(1, 30)) append_byte(rand_byte());
			return;
		end

		case ($urandom_range(0, 3))
			0: img_type = IMG_RAW_COLOUR;
			1: img_type = IMG_RAW_GREY;
			2: img_type = IMG_RLE_COLOUR;
			default: img_type = IMG_RLE_GREY;
		endcase
		if (shape == FILE_RUN_OVER || shape == FILE_HUGE)
			img_type = $urandom_range(0, 1) ? IMG_RLE_COLOUR : IMG_RLE_GREY;
		if (shape == FILE_BAD_TYPE) begin
			do img_type = rand_byte();
			while (img_type == IMG_RAW_COLOUR || img_type == IMG_RAW_GREY ||
				img_type == IMG_RLE_COLOUR || img_type == IMG_RLE_GREY);
		end
		rle = (img_type == IMG_RLE_COLOUR || img_type == IMG_RLE_GREY);

		case ($urandom_range(0, 2))
			0: bpp = BPP_GREY;
			1: bpp = BPP_RGB;
			default: bpp = BPP_RGBA;
		endcase
		if (shape == FILE_BAD_DEPTH) begin
			do bpp = rand_byte();
			while (bpp == BPP_GREY || bpp == BPP_RGB || bpp == BPP_RGBA);
		end
		nbytes = (bpp == BPP_RGB) ? 3 : (bpp == BPP_RGBA) ? 4 : 1;

		// mostly tiny images; the size extremes come from the error and huge shapes
		w = 16'($urandom_range(1, 4));
		h = 16'($urandom_range(1, 3));
		if ($urandom_range(0, 9) == 0)
			w = 16'($urandom_range(5, 12));
		if (shape == FILE_HUGE) begin
			w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
			h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
		end
		if (shape == FILE_CMAP || shape == FILE_BAD_TYPE) begin
			w = 16'($urandom_range(0, 65535));
			h = 16'($urandom_range(0, 65535));
		end
		if (shape == FILE_EMPTY) begin
			case ($urandom_range(0, 2))
				0: begin
					w = 16'd0;
					h = 16'($urandom_range(0, 65535));
				end
				1: begin
					w = 16'($urandom_range(0, 65535));
					h = 16'd0;
				end
				default: begin
					w = 16'd0;
					h = 16'd0;
				end
			endcase
		end
		id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;

		// 18-byte header, in file order
		append_byte(id_len);
		append_byte(shape == FILE_CMAP ? 8'($urandom_range(1, 255)) : 8'd0);
		append_byte(img_type);
		repeat (9) append_byte(rand_byte());  // colour-map spec and origin, unused
		append_byte(w[7:0]);
		append_byte(w[15:8]);
		append_byte(h[7:0]);
		append_byte(h[15:8]);
		append_byte(bpp);
		append_byte(rand_byte());  // descriptor
		if (shape == FILE_EOF_AT_HEADER)
			return;
		repeat (id_len) append_byte(rand_byte());

		// rejected files: a few bytes for the decoder to drain
		if (shape == FILE_CMAP || shape == FILE_BAD_TYPE || shape == FILE_EMPTY ||
			shape == FILE_BAD_DEPTH) begin
			repeat ($urandom_range(0, 3)) append_byte(rand_byte());
			return;
		end

		// pixel data
		owed = 32'(w) * 32'(h);
		if (!rle) begin
			repeat (owed * nbytes) append_byte(rand_byte());
		end else begin
			while (owed > 0) begin
				count = $urandom_range(1, (owed < 128) ? owed : 128);
				if (shape == FILE_RUN_OVER && ($urandom_range(0, 1) == 0 || count == owed)) begin
					// packet asking for more pixels than the image has left
					append_byte({1'($urandom_range(0, 1)), 7'($urandom_range(owed, 127))});
					repeat ($urandom_range(0, 3)) append_byte(rand_byte());
					return;
				end
				if (shape == FILE_HUGE && file_q.size() > 40)
					break;
				run = (shape == FILE_HUGE) ? 1'b1 : 1'($urandom_range(0, 1));
				append_byte({run, 7'(count - 1)});
				repeat (run ? nbytes : count * nbytes) append_byte(rand_byte());
				owed -= count;
			end
		end

		if (shape == FILE_TRAILING)
			repeat ($urandom_range(1, 4)) append_byte(rand_byte());
		if (shape == FILE_CUT) begin
			cut = $urandom_range(0, file_q.size() - 2);
			while (file_q.size() > cut + 1)
				void'(file_q.pop_back());
		end
	endtask

	// Main sequence
	initial begin
		file_shape_e shape;
		int unsigned roll;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one file of every shape first
		for (int k = 0; k <= FILE_NOISE; k++) begin
			build_file(file_shape_e'(k));
			send_file();
		end
		hold_until_drained();

		// random files; idling stops towards the end
		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= CALM_AFTER) begin
				send_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else begin
				send_gaps = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 45)
				shape = FILE_CLEAN;
			else if (roll < 55)
				shape = FILE_TRAILING;
			else if (roll < 70)
				shape = FILE_CUT;
			else if (roll < 77)
				shape = FILE_RUN_OVER;
			else if (roll < 81)
				shape = FILE_CMAP;
			else if (roll < 85)
				shape = FILE_BAD_TYPE;
			else if (roll < 89)
				shape = FILE_EMPTY;
			else if (roll < 94)
				shape = FILE_BAD_DEPTH;
			else if (roll < 96)
				shape = FILE_EOF_AT_HEADER;
			else if (roll < 98)
				shape = FILE_HUGE;
			else
				shape = FILE_NOISE;
			build_file(shape);
			send_file();
			if ($urandom_range(0, 7) == 0)
				hold_until_drained();
		end

		// let the last results out, then allow for the pipeline depth
		hold_until_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: files.f
rtl/tga_pkg.sv
rtl/tga_decode.sv
rtl/tga_out_reg.sv
rtl/tga_rle_image_decoder.sv
bench/tga_result_checker.sv
bench/tb_top.sv
